### rtl/rlc_pkg.sv
// Shared types and constants for the rectangle line clipper.
package rlc_pkg;

    localparam int CoordBits  = 12;
    localparam int NumBits    = CoordBits + 1;
    localparam int ProdBits   = 2 * NumBits;
    localparam int DivBits    = 2 * NumBits + 1;
    localparam int QuoBits    = NumBits;
    localparam int CfgIdxBits = 3;

    localparam logic [CfgIdxBits-1:0] RegXMin = 3'd0;
    localparam logic [CfgIdxBits-1:0] RegXMax = 3'd1;
    localparam logic [CfgIdxBits-1:0] RegYMin = 3'd2;
    localparam logic [CfgIdxBits-1:0] RegYMax = 3'd3;

    typedef logic signed [CoordBits-1:0] t_coord;
    typedef logic signed [NumBits-1:0]   t_num;

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
    } t_seg;

    typedef struct packed {
        logic   visible;
        t_coord leave_x;
        t_coord leave_y;
        t_coord enter_x;
        t_coord enter_y;
    } t_res;

    typedef struct packed {
        logic vld;
        logic rej;
        t_seg seg;
        t_num en_n;
        t_num en_d;
        t_num lv_n;
        t_num lv_d;
    } t_clip;

    typedef struct packed {
        logic [DivBits-1:0] rem;
        logic [NumBits-1:0] dn;
        logic [QuoBits-1:0] q;
        logic               neg;
    } t_div;

endpackage

### rtl/rlc_edge_cell.sv
// One window edge: tightens the entering or leaving bound of a segment, or rejects it.
module rlc_edge_cell #(
    parameter bit IsX  = 1'b0,
    parameter bit IsHi = 1'b0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rlc_pkg::t_coord i_edge,
    input  rlc_pkg::t_clip  i_clip,
    output rlc_pkg::t_clip  o_clip
);
    import rlc_pkg::*;

    t_clip r_clip, n_clip;
    logic  r_vld;
    t_num  p, q, d, e, tn, td, cur_n, cur_d;
    logic  pos, leaving, take;
    logic signed [ProdBits-1:0] lhs, rhs;

    always_comb begin
        p       = IsX ? t_num'(i_clip.seg.start_x) : t_num'(i_clip.seg.start_y);
        q       = IsX ? t_num'(i_clip.seg.end_x) : t_num'(i_clip.seg.end_y);
        e       = t_num'(i_edge);
        d       = q - p;
        pos     = !d[NumBits-1] && (d != '0);
        tn      = pos ? (e - p) : (p - e);
        td      = pos ? d : -d;
        leaving = IsHi ? pos : !pos;
        cur_n   = leaving ? i_clip.lv_n : i_clip.en_n;
        cur_d   = leaving ? i_clip.lv_d : i_clip.en_d;
        lhs     = tn * cur_d;
        rhs     = cur_n * td;
        take    = leaving ? (lhs < rhs) : (lhs > rhs);
        n_clip  = i_clip;
        if (d == '0) begin
            if (IsHi ? (p > e) : (p < e)) begin
                n_clip.rej = 1'b1;
            end
        end else if (take) begin
            if (leaving) begin
                n_clip.lv_n = tn;
                n_clip.lv_d = td;
            end else begin
                n_clip.en_n = tn;
                n_clip.en_d = td;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_clip <= n_clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_clip.vld;
        end
    end

    always_comb begin
        o_clip     = r_clip;
        o_clip.vld = r_vld;
    end

endmodule

### rtl/rlc_div_cell.sv
// One restoring-division step: settles one quotient bit.
module rlc_div_cell #(
    parameter int Shift = 0
) (
    input  logic          i_clk,
    input  rlc_pkg::t_div i_div,
    output rlc_pkg::t_div o_div
);
    import rlc_pkg::*;

    t_div r_div, n_div;
    logic [DivBits-1:0] sub;

    always_comb begin
        sub   = DivBits'(i_div.dn) << Shift;
        n_div = i_div;
        if (i_div.rem >= sub) begin
            n_div.rem      = i_div.rem - sub;
            n_div.q[Shift] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div <= n_div;
    end

    assign o_div = r_div;

endmodule

### rtl/rlc_lerp.sv
// Point on a segment at a rational parameter, truncated toward zero.
module rlc_lerp (
    input  logic            i_clk,
    input  rlc_pkg::t_coord i_a,
    input  rlc_pkg::t_coord i_b,
    input  rlc_pkg::t_num   i_n,
    input  rlc_pkg::t_num   i_dn,
    output rlc_pkg::t_coord o_val
);
    import rlc_pkg::*;

    logic signed [CoordBits+NumBits-1:0] r_p1;
    logic signed [ProdBits-1:0]          r_p2;
    logic [NumBits-1:0]                  r_dn;
    t_num                                diff;
    logic signed [DivBits-1:0]           num;
    t_div                                r_div0;
    t_div                                chain [QuoBits+1];
    logic [QuoBits-1:0]                  qs;

    assign diff = t_num'(i_b) - t_num'(i_a);

    always_ff @(posedge i_clk) begin
        r_p1 <= i_a * i_dn;
        r_p2 <= i_n * diff;
        r_dn <= i_dn;
    end

    assign num = DivBits'(r_p1) + DivBits'(r_p2);

    always_ff @(posedge i_clk) begin
        r_div0.neg <= num[DivBits-1];
        r_div0.rem <= num[DivBits-1] ? DivBits'(-num) : DivBits'(num);
        r_div0.dn  <= r_dn;
        r_div0.q   <= '0;
    end

    assign chain[0] = r_div0;

    for (genvar s = 0; s < QuoBits; s++) begin : g_div
        rlc_div_cell #(.Shift(QuoBits - 1 - s)) u_cell (
            .i_clk(i_clk),
            .i_div(chain[s]),
            .o_div(chain[s+1])
        );
    end

    assign qs    = chain[QuoBits].neg ? -chain[QuoBits].q : chain[QuoBits].q;
    assign o_val = qs[CoordBits-1:0];

endmodule

### rtl/rect_line_clipper_unit.sv
// Top level of the rectangle line clipper.
// Clips one segment per word against the window held in four registers.
// Input: raise i_start with the segment on i_seg; o_busy is always low, so
// a word is taken at every clock edge where i_start is high, one per cycle.
// Output: o_done is high for one cycle with the word on o_res; the receiver
// cannot stall and must take it then. Stages in order: the edge cells for
// top, bottom, right and left, a register of products, one of sums, one
// divide step per quotient bit (13), and the output register. Throughput
// is one word per cycle; every stage is fully pipelined.
// A segment outside the window gives visible low and all points zero.
// Config: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 x_min,
// 1 x_max, 2 y_min, 3 y_max); other indexes are ignored. Write only while
// no word is in flight. Reset restores the window to -320..319, -240..239
// and drops any words in flight.
module rect_line_clipper_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  rlc_pkg::t_seg                      i_seg,
    output logic                               o_done,
    output rlc_pkg::t_res                      o_res,
    input  logic                               i_cfg_we,
    input  logic [rlc_pkg::CfgIdxBits-1:0]     i_cfg_idx,
    input  logic [rlc_pkg::CoordBits-1:0]      i_cfg_data
);
    import rlc_pkg::*;

    localparam int Dly = QuoBits + 2;

    t_coord r_xmin, r_xmax, r_ymin, r_ymax;
    t_clip  clip [5];
    logic   vis_c;
    logic signed [ProdBits-1:0] vl, vr;
    logic [Dly-1:0] r_vld_d, r_vis_d;
    t_coord lx, ly, ex, ey;
    logic   r_done;
    t_res   r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xmin <= t_coord'(-320);
            r_xmax <= t_coord'(319);
            r_ymin <= t_coord'(-240);
            r_ymax <= t_coord'(239);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                RegXMin: r_xmin <= i_cfg_data;
                RegXMax: r_xmax <= i_cfg_data;
                RegYMin: r_ymin <= i_cfg_data;
                RegYMax: r_ymax <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    always_comb begin
        clip[0].vld  = i_start;
        clip[0].rej  = 1'b0;
        clip[0].seg  = i_seg;
        clip[0].en_n = t_num'(0);
        clip[0].en_d = t_num'(1);
        clip[0].lv_n = t_num'(1);
        clip[0].lv_d = t_num'(1);
    end

    rlc_edge_cell #(.IsX(1'b0), .IsHi(1'b1)) u_ytop (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_edge(r_ymax),
        .i_clip(clip[0]), .o_clip(clip[1])
    );
    rlc_edge_cell #(.IsX(1'b0), .IsHi(1'b0)) u_ybot (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_edge(r_ymin),
        .i_clip(clip[1]), .o_clip(clip[2])
    );
    rlc_edge_cell #(.IsX(1'b1), .IsHi(1'b1)) u_xright (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_edge(r_xmax),
        .i_clip(clip[2]), .o_clip(clip[3])
    );
    rlc_edge_cell #(.IsX(1'b1), .IsHi(1'b0)) u_xleft (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_edge(r_xmin),
        .i_clip(clip[3]), .o_clip(clip[4])
    );

    assign vl    = clip[4].en_n * clip[4].lv_d;
    assign vr    = clip[4].lv_n * clip[4].en_d;
    assign vis_c = !clip[4].rej && (vl <= vr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_d <= '0;
        end else begin
            r_vld_d <= {r_vld_d[Dly-2:0], clip[4].vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_vis_d <= {r_vis_d[Dly-2:0], vis_c};
    end

    rlc_lerp u_lx (
        .i_clk(i_clk), .i_a(clip[4].seg.start_x), .i_b(clip[4].seg.end_x),
        .i_n(clip[4].lv_n), .i_dn(clip[4].lv_d), .o_val(lx)
    );
    rlc_lerp u_ly (
        .i_clk(i_clk), .i_a(clip[4].seg.start_y), .i_b(clip[4].seg.end_y),
        .i_n(clip[4].lv_n), .i_dn(clip[4].lv_d), .o_val(ly)
    );
    rlc_lerp u_ex (
        .i_clk(i_clk), .i_a(clip[4].seg.start_x), .i_b(clip[4].seg.end_x),
        .i_n(clip[4].en_n), .i_dn(clip[4].en_d), .o_val(ex)
    );
    rlc_lerp u_ey (
        .i_clk(i_clk), .i_a(clip[4].seg.start_y), .i_b(clip[4].seg.end_y),
        .i_n(clip[4].en_n), .i_dn(clip[4].en_d), .o_val(ey)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vld_d[Dly-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.visible <= r_vis_d[Dly-1];
        r_res.leave_x <= r_vis_d[Dly-1] ? lx : '0;
        r_res.leave_y <= r_vis_d[Dly-1] ? ly : '0;
        r_res.enter_x <= r_vis_d[Dly-1] ? ex : '0;
        r_res.enter_y <= r_vis_d[Dly-1] ? ey : '0;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule
